// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is asserted.
`define WSS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define WSS_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/wss_pkg.sv =====
// ----------------------------------------------------------------------------
// wss_pkg
// Types and constants of the window sample statistics unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wss_pkg;

  localparam int unsigned TIME_W          = 18;
  localparam int unsigned VAL_W           = 16;
  localparam int unsigned SD_W            = 16;
  localparam int unsigned WCNT_W          = 13;
  localparam int unsigned MAX_SAMPLES_DEF = 4096;

  // shared datapath width and its step counter
  localparam int unsigned ALU_W  = 64;
  localparam int unsigned STEP_W = 7;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 18;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_END   = 1'b1;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_e;

  typedef struct packed {
    logic              start;
    alu_op_e           op;
    logic [STEP_W-1:0] steps;
  } alu_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_PMUL,
    ST_PDIV,
    ST_UPD,
    ST_FINAL,
    ST_MEAN,
    ST_SQA,
    ST_SQB,
    ST_DEN,
    ST_QUO,
    ST_ROOT,
    ST_LOAD
  } wss_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/wss_sample_if.sv =====
// ----------------------------------------------------------------------------
// wss_sample_if
// Sample request channel: valid/ready plus one timed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface wss_sample_if
  import wss_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        sample_time;
  logic signed [VAL_W-1:0]  sample_value;
  logic                     has_sample;
  logic                     last;

  modport source (output valid, sample_time, sample_value, has_sample, last, input ready);
  modport sink   (input valid, sample_time, sample_value, has_sample, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wss_result_if.sv =====
// ----------------------------------------------------------------------------
// wss_result_if
// Result channel: valid/ready plus the statistics of one sample set.
// ----------------------------------------------------------------------------
`default_nettype none

interface wss_result_if
  import wss_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] mean;
  logic signed [VAL_W-1:0] maximum;
  logic signed [VAL_W-1:0] minimum;
  logic [SD_W-1:0]         std_dev;
  logic signed [VAL_W-1:0] value_at_start;
  logic signed [VAL_W-1:0] value_at_middle;
  logic signed [VAL_W-1:0] value_at_end;
  logic [WCNT_W-1:0]       window_count;

  modport source (output valid, mean, maximum, minimum, std_dev, value_at_start,
                  value_at_middle, value_at_end, window_count, input ready);
  modport sink   (input valid, mean, maximum, minimum, std_dev, value_at_start,
                  value_at_middle, value_at_end, window_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/wss_alu.sv =====
// ----------------------------------------------------------------------------
// wss_alu
// Shared iterative unit: shift-add multiply, restoring divide and
// digit-by-digit square root, one add/subtract per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wss_alu
  import wss_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire alu_ctrl_t        ctrl_i,
  input  wire logic [ALU_W-1:0] a_i,
  input  wire logic [ALU_W-1:0] b_i,
  output      alu_stat_t        stat_o,
  output      logic [ALU_W-1:0] result_o
);

  logic              busy_q, busy_d, done_q, done_d;
  alu_op_e           op_q, op_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [ALU_W-1:0]  acc_q, acc_d, x_q, x_d, y_q, y_d, d_q, d_d;

  logic [STEP_W-1:0] shamt;
  logic [ALU_W:0]    div_t;
  logic [ALU_W-1:0]  sq_r, sq_trial;

  assign shamt    = STEP_W'(ALU_W) - ctrl_i.steps;
  assign div_t    = {acc_q, y_q[ALU_W-1]};
  assign sq_r     = {acc_q[ALU_W-3:0], y_q[ALU_W-1 -: 2]};
  assign sq_trial = {x_q[ALU_W-3:0], 2'b01};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    d_d    = d_q;
    if (ctrl_i.start && !busy_q) begin
      busy_d = 1'b1;
      op_d   = ctrl_i.op;
      cnt_d  = ctrl_i.steps;
      acc_d  = '0;
      d_d    = b_i;
      case (ctrl_i.op)
        ALU_MUL: begin
          x_d = a_i;
          y_d = b_i << shamt;
        end
        ALU_DIV: begin
          x_d = '0;
          y_d = a_i << shamt;
        end
        default: begin
          x_d = '0;
          y_d = a_i;
        end
      endcase
    end else if (busy_q) begin
      case (op_q)
        ALU_MUL: begin
          acc_d = {acc_q[ALU_W-2:0], 1'b0} + (y_q[ALU_W-1] ? x_q : '0);
          y_d   = {y_q[ALU_W-2:0], 1'b0};
        end
        ALU_DIV: begin
          if (div_t >= {1'b0, d_q}) begin
            acc_d = ALU_W'(div_t - {1'b0, d_q});
            y_d   = {y_q[ALU_W-2:0], 1'b1};
          end else begin
            acc_d = div_t[ALU_W-1:0];
            y_d   = {y_q[ALU_W-2:0], 1'b0};
          end
        end
        default: begin
          if (sq_r >= sq_trial) begin
            acc_d = sq_r - sq_trial;
            x_d   = {x_q[ALU_W-2:0], 1'b1};
          end else begin
            acc_d = sq_r;
            x_d   = {x_q[ALU_W-2:0], 1'b0};
          end
          y_d = {y_q[ALU_W-3:0], 2'b00};
        end
      endcase
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    d_q   <= d_d;
  end

  always_comb begin
    case (op_q)
      ALU_MUL: result_o = acc_q;
      ALU_DIV: result_o = y_q;
      default: result_o = x_q;
    endcase
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

  `WSS_ASSERT(a_start_idle, ctrl_i.start |-> !busy_q, "alu started while busy")
  `WSS_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "alu done without work")
  `WSS_ASSERT(a_busy_holds, (busy_q && cnt_q != STEP_W'(1)) |=> busy_q,
              "alu stopped early")

endmodule

`default_nettype wire

// ===== hw/rtl/wss_acc.sv =====
// ----------------------------------------------------------------------------
// wss_acc
// In-window accumulator: count, sum, sum of squares, maximum and minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module wss_acc
  import wss_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1),
  parameter int unsigned SUM_W       = VAL_W + CNT_W,
  parameter int unsigned SQ_W        = 2 * VAL_W - 1 + CNT_W
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    upd_i,
  input  wire logic                    clr_i,
  input  wire logic [TIME_W-1:0]       time_i,
  input  wire logic signed [VAL_W-1:0] value_i,
  input  wire logic [TIME_W-1:0]       win_start_i,
  input  wire logic [TIME_W-1:0]       win_end_i,
  output      logic [CNT_W-1:0]        count_o,
  output      logic signed [SUM_W-1:0] sum_o,
  output      logic [SQ_W-1:0]         sq_o,
  output      logic signed [VAL_W-1:0] max_o,
  output      logic signed [VAL_W-1:0] min_o
);

  logic [CNT_W-1:0]          count_q, count_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SQ_W-1:0]           sq_q, sq_d;
  logic signed [VAL_W-1:0]   max_q, max_d, min_q, min_d;
  logic signed [2*VAL_W-1:0] prod;
  logic                      take;

  assign prod = value_i * value_i;
  assign take = upd_i && (time_i >= win_start_i) && (time_i <= win_end_i)
                && (count_q < CNT_W'(MAX_SAMPLES));

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    sq_d    = sq_q;
    max_d   = max_q;
    min_d   = min_q;
    if (clr_i) begin
      count_d = '0;
      sum_d   = '0;
      sq_d    = '0;
      max_d   = '0;
      min_d   = '0;
    end else if (take) begin
      count_d = count_q + 1'b1;
      sum_d   = sum_q + SUM_W'(value_i);
      sq_d    = sq_q + SQ_W'(prod[2*VAL_W-2:0]);
      if (count_q == '0 || value_i > max_q) max_d = value_i;
      if (count_q == '0 || value_i < min_q) min_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
      max_q   <= '0;
      min_q   <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
      max_q   <= max_d;
      min_q   <= min_d;
    end
  end

  assign count_o = count_q;
  assign sum_o   = sum_q;
  assign sq_o    = sq_q;
  assign max_o   = max_q;
  assign min_o   = min_q;

endmodule

`default_nettype wire

// ===== hw/rtl/window_sample_statistics_unit.sv =====
// Sample without closing the set: accept, three probe checks and update, plus a
// 16-step multiply and a 34-step divide per probe that needs interpolation.
// Closing item: adds mean divide, three multiplies, a 64-step divide and a
// 32-step root on the shared unit.
// One request is worked at a time; the result register frees the input side.
// Reset (async, active low) clears set state and sets the window to 0..262143.
// ----------------------------------------------------------------------------
// window_sample_statistics_unit
// Windowed mean, max, min, sample standard deviation and interpolated probes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module window_sample_statistics_unit
  import wss_pkg::*;
#(
  parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  wss_sample_if.sink                 sample_i,
  wss_result_if.source               result_o
);

  localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W = VAL_W + CNT_W;
  localparam int unsigned SQ_W  = 2 * VAL_W - 1 + CNT_W;
  localparam int unsigned PMUL_STEPS = VAL_W;
  localparam int unsigned PDIV_STEPS = TIME_W + VAL_W;
  localparam int unsigned Q_W = PDIV_STEPS + 2;

  logic [TIME_W-1:0] win_start_q, win_end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= '0;
      win_end_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIN_START: win_start_q <= cfg_data_i;
        CFG_WIN_END:   win_end_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  wss_state_e              st_q, st_d;
  logic [TIME_W-1:0]       t_q, t_d, prev_time_q, prev_time_d;
  logic signed [VAL_W-1:0] v_q, v_d, prev_value_q, prev_value_d;
  logic                    last_q, last_d, seen_q, seen_d, neg_q, neg_d;
  logic [1:0]              k_q, k_d;
  logic [2:0]              pfound_q, pfound_d;
  logic signed [VAL_W-1:0] pval_q [3];
  logic signed [VAL_W-1:0] pval_d [3];
  logic [ALU_W-1:0]        a_q, a_d, num_q, num_d;
  logic signed [VAL_W-1:0] mean_q, mean_d;
  logic [SD_W-1:0]         sd_q, sd_d;

  logic                    out_valid_q, out_valid_d, load;
  logic signed [VAL_W-1:0] o_mean_q, o_max_q, o_min_q, o_ps_q, o_pm_q, o_pe_q;
  logic [SD_W-1:0]         o_sd_q;
  logic [WCNT_W-1:0]       o_cnt_q;

  alu_ctrl_t        alu_ctrl;
  alu_stat_t        alu_stat;
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;

  logic                    acc_upd, acc_clr;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq;
  logic signed [VAL_W-1:0] vmax, vmin;

  wss_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (alu_ctrl),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .stat_o   (alu_stat),
    .result_o (alu_res)
  );

  wss_acc #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .SQ_W        (SQ_W)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .upd_i       (acc_upd),
    .clr_i       (acc_clr),
    .time_i      (sample_i.sample_time),
    .value_i     (sample_i.sample_value),
    .win_start_i (win_start_q),
    .win_end_i   (win_end_q),
    .count_o     (count),
    .sum_o       (sum),
    .sq_o        (sq),
    .max_o       (vmax),
    .min_o       (vmin)
  );

  // probe time and interpolation operands
  logic [TIME_W:0]          mid_sum;
  logic [TIME_W-1:0]        pt, den;
  logic signed [TIME_W:0]   pnum;
  logic signed [VAL_W:0]    pdiff;
  logic [TIME_W-1:0]        pnum_mag;
  logic [VAL_W-1:0]         pdiff_mag;
  logic signed [Q_W-1:0]    q_s, interp;
  logic signed [VAL_W-1:0]  interp_sat;
  logic [SUM_W-1:0]         sum_mag;

  assign mid_sum = {1'b0, win_start_q} + {1'b0, win_end_q};

  always_comb begin
    case (k_q)
      2'd0:    pt = win_start_q;
      2'd1:    pt = mid_sum[TIME_W:1];
      default: pt = win_end_q;
    endcase
  end

  assign den       = t_q - prev_time_q;
  assign pnum      = $signed({1'b0, pt}) - $signed({1'b0, prev_time_q});
  assign pdiff     = $signed({v_q[VAL_W-1], v_q}) - $signed({prev_value_q[VAL_W-1], prev_value_q});
  assign pnum_mag  = TIME_W'(pnum[TIME_W] ? -pnum : pnum);
  assign pdiff_mag = VAL_W'(pdiff[VAL_W] ? -pdiff : pdiff);
  assign q_s       = $signed({2'b00, alu_res[PDIV_STEPS-1:0]});
  assign interp    = Q_W'(prev_value_q) + (neg_q ? -q_s : q_s);
  assign sum_mag   = SUM_W'(sum[SUM_W-1] ? -sum : sum);

  always_comb begin
    if (interp > Q_W'(32767))       interp_sat = 16'sh7fff;
    else if (interp < -Q_W'(32768)) interp_sat = -16'sh8000;
    else                            interp_sat = interp[VAL_W-1:0];
  end

  always_comb begin
    st_d         = st_q;
    t_d          = t_q;
    v_d          = v_q;
    last_d       = last_q;
    k_d          = k_q;
    neg_d        = neg_q;
    prev_time_d  = prev_time_q;
    prev_value_d = prev_value_q;
    seen_d       = seen_q;
    pfound_d     = pfound_q;
    pval_d       = pval_q;
    a_d          = a_q;
    num_d        = num_q;
    mean_d       = mean_q;
    sd_d         = sd_q;
    alu_ctrl     = '{start: 1'b0, op: ALU_MUL, steps: '0};
    alu_a        = '0;
    alu_b        = '0;
    acc_upd      = 1'b0;
    acc_clr      = 1'b0;
    load         = 1'b0;
    sample_i.ready = (st_q == ST_IDLE);

    case (st_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          t_d     = sample_i.sample_time;
          v_d     = sample_i.sample_value;
          last_d  = sample_i.last;
          k_d     = '0;
          acc_upd = sample_i.has_sample;
          if (sample_i.has_sample)  st_d = ST_PROBE;
          else if (sample_i.last)   st_d = ST_FINAL;
        end
      end
      ST_PROBE: begin
        if (!pfound_q[k_q] && t_q >= pt) begin
          pfound_d[k_q] = 1'b1;
          if (!seen_q || t_q <= prev_time_q) begin
            pval_d[k_q] = v_q;
          end else begin
            alu_ctrl = '{start: 1'b1, op: ALU_MUL, steps: STEP_W'(PMUL_STEPS)};
            alu_a    = ALU_W'(pnum_mag);
            alu_b    = ALU_W'(pdiff_mag);
            neg_d    = pnum[TIME_W] ^ pdiff[VAL_W];
            st_d     = ST_PMUL;
          end
        end
        if (st_d == ST_PROBE) begin
          if (k_q == 2'd2) st_d = ST_UPD;
          else             k_d  = k_q + 1'b1;
        end
      end
      ST_PMUL: begin
        if (alu_stat.done) begin
          alu_ctrl = '{start: 1'b1, op: ALU_DIV, steps: STEP_W'(PDIV_STEPS)};
          alu_a    = alu_res;
          alu_b    = ALU_W'(den);
          st_d     = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (alu_stat.done) begin
          pval_d[k_q] = interp_sat;
          if (k_q == 2'd2) begin
            st_d = ST_UPD;
          end else begin
            k_d  = k_q + 1'b1;
            st_d = ST_PROBE;
          end
        end
      end
      ST_UPD: begin
        prev_time_d  = t_q;
        prev_value_d = v_q;
        seen_d       = 1'b1;
        st_d         = last_q ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        if (count != '0) begin
          alu_ctrl = '{start: 1'b1, op: ALU_DIV, steps: STEP_W'(SUM_W)};
          alu_a    = ALU_W'(sum_mag);
          alu_b    = ALU_W'(count);
          st_d     = ST_MEAN;
        end else begin
          mean_d = '0;
          sd_d   = '0;
          st_d   = ST_LOAD;
        end
      end
      ST_MEAN: begin
        if (alu_stat.done) begin
          mean_d = sum[SUM_W-1] ? -VAL_W'(alu_res) : VAL_W'(alu_res);
          if (count > CNT_W'(1)) begin
            alu_ctrl = '{start: 1'b1, op: ALU_MUL, steps: STEP_W'(CNT_W)};
            alu_a    = ALU_W'(sq);
            alu_b    = ALU_W'(count);
            st_d     = ST_SQA;
          end else begin
            sd_d = '0;
            st_d = ST_LOAD;
          end
        end
      end
      ST_SQA: begin
        if (alu_stat.done) begin
          a_d      = alu_res;
          alu_ctrl = '{start: 1'b1, op: ALU_MUL, steps: STEP_W'(SUM_W)};
          alu_a    = ALU_W'(sum_mag);
          alu_b    = ALU_W'(sum_mag);
          st_d     = ST_SQB;
        end
      end
      ST_SQB: begin
        if (alu_stat.done) begin
          num_d    = (a_q > alu_res) ? a_q - alu_res : '0;
          alu_ctrl = '{start: 1'b1, op: ALU_MUL, steps: STEP_W'(CNT_W)};
          alu_a    = ALU_W'(count);
          alu_b    = ALU_W'(count - 1'b1);
          st_d     = ST_DEN;
        end
      end
      ST_DEN: begin
        if (alu_stat.done) begin
          alu_ctrl = '{start: 1'b1, op: ALU_DIV, steps: STEP_W'(ALU_W)};
          alu_a    = num_q;
          alu_b    = alu_res;
          st_d     = ST_QUO;
        end
      end
      ST_QUO: begin
        if (alu_stat.done) begin
          alu_ctrl = '{start: 1'b1, op: ALU_SQRT, steps: STEP_W'(ALU_W / 2)};
          alu_a    = alu_res;
          st_d     = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (alu_stat.done) begin
          sd_d = (alu_res > ALU_W'(16'hffff)) ? '1 : alu_res[SD_W-1:0];
          st_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_q || result_o.ready) begin
          load         = 1'b1;
          acc_clr      = 1'b1;
          prev_time_d  = '0;
          prev_value_d = '0;
          seen_d       = 1'b0;
          pfound_d     = '0;
          pval_d       = '{default: '0};
          st_d         = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      prev_time_q  <= '0;
      prev_value_q <= '0;
      seen_q       <= 1'b0;
      pfound_q     <= '0;
      pval_q       <= '{default: '0};
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      prev_time_q  <= prev_time_d;
      prev_value_q <= prev_value_d;
      seen_q       <= seen_d;
      pfound_q     <= pfound_d;
      pval_q       <= pval_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    v_q    <= v_d;
    last_q <= last_d;
    neg_q  <= neg_d;
    a_q    <= a_d;
    num_q  <= num_d;
    mean_q <= mean_d;
    sd_q   <= sd_d;
  end

  // result register
  assign out_valid_d = load ? 1'b1 : (out_valid_q && !result_o.ready);

  function automatic logic signed [VAL_W-1:0] probe_out(input logic found,
                                                       input logic signed [VAL_W-1:0] pv,
                                                       input logic seen,
                                                       input logic signed [VAL_W-1:0] lv);
    if (found)     return pv;
    else if (seen) return lv;
    else           return '0;
  endfunction

  always_ff @(posedge clk_i) begin
    if (load) begin
      o_mean_q <= mean_q;
      o_max_q  <= vmax;
      o_min_q  <= vmin;
      o_sd_q   <= sd_q;
      o_ps_q   <= probe_out(pfound_q[0], pval_q[0], seen_q, prev_value_q);
      o_pm_q   <= probe_out(pfound_q[1], pval_q[1], seen_q, prev_value_q);
      o_pe_q   <= probe_out(pfound_q[2], pval_q[2], seen_q, prev_value_q);
      o_cnt_q  <= (32'(count) > 32'd8191) ? '1 : WCNT_W'(count);
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.mean            = o_mean_q;
  assign result_o.maximum         = o_max_q;
  assign result_o.minimum         = o_min_q;
  assign result_o.std_dev         = o_sd_q;
  assign result_o.value_at_start  = o_ps_q;
  assign result_o.value_at_middle = o_pm_q;
  assign result_o.value_at_end    = o_pe_q;
  assign result_o.window_count    = o_cnt_q;

  `WSS_ASSERT(a_ready_alu_idle, sample_i.ready |-> !alu_stat.busy,
              "sample request taken while the shared unit works")
  `WSS_ASSERT(a_result_from_load, $rose(result_o.valid) |-> $past(st_q == ST_LOAD),
              "result raised outside the load step")
  `WSS_ASSERT(a_probe_sticky, (pfound_q[0] && st_q != ST_LOAD) |=> pfound_q[0],
              "decided start probe lost before the set closed")

endmodule

`default_nettype wire
